[rtl/core/sacl_pkg.sv]
`default_nettype none
package sacl_pkg;

  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 4;

  localparam int ADDR_W   = 64;
  localparam int TOTAL_W  = 32;
  localparam int SB_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int OUT_W    = 104;

  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS        = 2'd2;

  localparam logic [1:0] REQ_MODIFY = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic hit;
    logic evict;
  } lookup_t;

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] v,
                                                 input logic [1:0] inc);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, v} + {{(TOTAL_W-1){1'b0}}, inc};
    return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/core/sacl_store.sv]
`default_nettype none
module sacl_store #(
  parameter int AW     = 6,
  parameter int DEPTH  = 64,
  parameter int TAG_W  = 256,
  parameter int META_W = 12
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  input  wire logic              wr_en,
  input  wire logic              tag_we,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [TAG_W-1:0]  wr_tag_row,
  input  wire logic [META_W-1:0] wr_meta_row,
  output logic      [TAG_W-1:0]  rd_tag_row,
  output logic      [META_W-1:0] rd_meta_row
);

  logic [TAG_W-1:0]  tag_mem  [DEPTH];
  logic [META_W-1:0] meta_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[wr_addr] <= wr_tag_row;
    end
    if (rd_en) begin
      rd_tag_row <= tag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      meta_mem[wr_addr] <= wr_meta_row;
    end
    if (rd_en) begin
      rd_meta_row <= meta_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/sacl_match.sv]
`default_nettype none
module sacl_match
  import sacl_pkg::*;
#(
  parameter int MAX_WAYS = 4,
  parameter int RW       = 2,
  parameter int WCW      = 3
) (
  input  wire logic [MAX_WAYS-1:0][ADDR_W-1:0] tag_row,
  input  wire logic [MAX_WAYS-1:0]             valid,
  input  wire logic [MAX_WAYS-1:0][RW-1:0]     rank,
  input  wire logic [ADDR_W-1:0]               tag,
  input  wire logic [WCW-1:0]                  ways_eff,
  output lookup_t                              res,
  output logic      [MAX_WAYS-1:0][ADDR_W-1:0] new_tag_row,
  output logic      [MAX_WAYS-1:0]             new_valid,
  output logic      [MAX_WAYS-1:0][RW-1:0]     new_rank
);

  logic [RW-1:0] found;
  logic [RW-1:0] victim;
  logic [RW-1:0] hit_rank;
  logic [RW-1:0] last_rank;
  logic          hit;

  always_comb begin
    hit       = 1'b0;
    found     = '0;
    victim    = '0;
    last_rank = RW'(ways_eff - WCW'(1));
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WCW'(i) < ways_eff && valid[i] && tag_row[i] == tag) begin
        hit   = 1'b1;
        found = RW'(i);
      end
      if (WCW'(i) < ways_eff && rank[i] == last_rank) begin
        victim = RW'(i);
      end
    end
    hit_rank = rank[found];

    new_tag_row = tag_row;
    new_valid   = valid;
    new_rank    = rank;
    if (hit) begin
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (WCW'(i) < ways_eff && rank[i] < hit_rank) begin
          new_rank[i] = rank[i] + RW'(1);
        end
      end
      new_rank[found] = '0;
    end else begin
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (WCW'(i) < ways_eff) begin
          new_rank[i] = (rank[i] == last_rank) ? '0 : rank[i] + RW'(1);
        end
      end
      new_valid[victim]   = 1'b1;
      new_tag_row[victim] = tag;
    end

    res.hit   = hit;
    res.evict = !hit && valid[victim];
  end

endmodule
`default_nettype wire

[rtl/core/set_assoc_cache_lru_sim.sv]
// Set-associative cache hit/miss counter with true LRU replacement.
// Input beat: s_tuser carries the access kind (load, store, modify), s_tdata
// the 64-bit byte address. One result beat per access on m_tdata: hits,
// miss and eviction flags of this access plus the saturating running totals.
// For each access the set row is read from the synchronous tag
// and metadata memories in the cycle the beat is taken, then compared,
// updated and written back in the lookup state, which also loads the result register.
// A modify is resolved in the same pass, its store half always hitting.
// s_tready is high only in the idle state, so one access is in flight at a time.
// While a result is pending and m_tready is low, the result register holds and the lookup
// waits, keeping its memory read data, until the result is taken.
// Reset, and any write to a known register on the cfg channel, starts a
// clearing pass over all 2**MAX_SET_BITS sets (64 by default) that invalidates
// every set and restores the recency order; no access is taken meanwhile.
// Reset also zeroes the totals and loads set bits 0, offset bits 0, ways 1.
// cfg_ready is always high; write only while the block is idle.
`default_nettype none
module set_assoc_cache_lru_sim
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [ADDR_W-1:0]     s_tdata,   // address
  input  wire logic [1:0]            s_tuser,   // req_type
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // hits_now, miss_now, evict_now, total_hits, total_misses, total_evictions
  output logic      [OUT_W-1:0]      m_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SET_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int DEPTH  = 2 ** MAX_SET_BITS;
  localparam int RW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCW    = $clog2(MAX_WAYS + 1);
  localparam int META_W = MAX_WAYS * (RW + 1);
  localparam int TAG_RW = MAX_WAYS * ADDR_W;
  localparam int PAD_W  = OUT_W - 4 - 3 * TOTAL_W;

  state_t state;
  state_t state_next;

  logic [2:0]            set_index_bits;
  logic [5:0]            block_offset_bits;
  logic [2:0]            ways_in_use;
  logic [TOTAL_W-1:0]    hit_total;
  logic [TOTAL_W-1:0]    miss_total;
  logic [TOTAL_W-1:0]    evict_total;
  logic [SET_AW-1:0]     clr_addr;
  logic [SET_AW-1:0]     clr_addr_next;

  logic [SET_AW-1:0]     req_set;
  logic [ADDR_W-1:0]     req_tag;
  logic                  req_modify;
  logic [1:0]            res_hits;
  logic                  res_miss;
  logic                  res_evict;

  logic                  cfg_hit;
  logic                  accept;
  logic                  adv;
  logic                  clr_last;
  logic [WCW-1:0]        ways_eff;
  logic [SB_W-1:0]       sb;
  logic [SET_AW:0]       one_sh;
  logic [SET_AW-1:0]     set_mask;
  logic [ADDR_W-1:0]     blk;
  logic [6:0]            tag_sh;
  logic [SET_AW-1:0]     set_calc;
  logic [ADDR_W-1:0]     tag_calc;
  logic [MAX_WAYS-1:0][RW-1:0] init_rank;
  logic [1:0]            hit_inc;

  logic [TAG_RW-1:0]     rd_tag_row;
  logic [META_W-1:0]     rd_meta_row;
  logic [META_W-1:0]     wr_meta_row;
  logic [SET_AW-1:0]     wr_addr;
  logic                  wr_en;
  logic                  tag_we;

  lookup_t                           lk;
  logic [MAX_WAYS-1:0][ADDR_W-1:0]   new_tag_row;
  logic [MAX_WAYS-1:0]               new_valid;
  logic [MAX_WAYS-1:0][RW-1:0]       new_rank;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == REG_SET_BITS ||
                     cfg_index == REG_OFFSET_BITS || cfg_index == REG_WAYS);
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign adv       = !m_tvalid || m_tready;
  assign clr_last  = (clr_addr == SET_AW'(DEPTH - 1));

  // effective geometry
  always_comb begin
    if (ways_in_use == 3'd0) begin
      ways_eff = WCW'(1);
    end else if (int'(ways_in_use) > MAX_WAYS) begin
      ways_eff = WCW'(MAX_WAYS);
    end else begin
      ways_eff = WCW'(ways_in_use);
    end
    if (int'(set_index_bits) > MAX_SET_BITS) begin
      sb = SB_W'(MAX_SET_BITS);
    end else begin
      sb = SB_W'(set_index_bits);
    end
    one_sh   = (SET_AW + 1)'(1) << sb;
    set_mask = SET_AW'(one_sh - (SET_AW + 1)'(1));
    blk      = s_tdata >> block_offset_bits;
    set_calc = blk[SET_AW-1:0] & set_mask;
    tag_sh   = {1'b0, block_offset_bits} + 7'(sb);
    tag_calc = tag_sh[6] ? '0 : (s_tdata >> tag_sh[5:0]);
    for (int j = 0; j < MAX_WAYS; j++) begin
      init_rank[j] = (WCW'(j) < ways_eff) ? RW'(ways_eff - WCW'(1) - WCW'(j)) : '0;
    end
  end

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    case (state)
      ST_CLEAR: begin
        clr_addr_next = clr_addr + SET_AW'(1);
        if (clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (adv) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
    if (cfg_hit) begin
      state_next    = ST_CLEAR;
      clr_addr_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits    <= 3'd0;
      block_offset_bits <= 6'd0;
      ways_in_use       <= 3'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SET_BITS:    set_index_bits    <= cfg_data[2:0];
        REG_OFFSET_BITS: block_offset_bits <= cfg_data;
        REG_WAYS:        ways_in_use       <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_set    <= set_calc;
      req_tag    <= tag_calc;
      req_modify <= (s_tuser == REQ_MODIFY);
    end
  end

  // memory access
  assign wr_en   = (state == ST_CLEAR) || (state == ST_LOOKUP && adv);
  assign tag_we  = (state == ST_LOOKUP) && adv && !lk.hit;
  assign wr_addr = (state == ST_CLEAR) ? clr_addr : req_set;
  assign wr_meta_row = (state == ST_CLEAR) ? {init_rank, {MAX_WAYS{1'b0}}}
                                           : {new_rank, new_valid};

  sacl_store #(
    .AW     (SET_AW),
    .DEPTH  (DEPTH),
    .TAG_W  (TAG_RW),
    .META_W (META_W)
  ) u_store (
    .clk         (clk),
    .rd_en       (accept),
    .rd_addr     (set_calc),
    .wr_en       (wr_en),
    .tag_we      (tag_we),
    .wr_addr     (wr_addr),
    .wr_tag_row  (new_tag_row),
    .wr_meta_row (wr_meta_row),
    .rd_tag_row  (rd_tag_row),
    .rd_meta_row (rd_meta_row)
  );

  sacl_match #(
    .MAX_WAYS (MAX_WAYS),
    .RW       (RW),
    .WCW      (WCW)
  ) u_match (
    .tag_row     (rd_tag_row),
    .valid       (rd_meta_row[MAX_WAYS-1:0]),
    .rank        (rd_meta_row[META_W-1:MAX_WAYS]),
    .tag         (req_tag),
    .ways_eff    (ways_eff),
    .res         (lk),
    .new_tag_row (new_tag_row),
    .new_valid   (new_valid),
    .new_rank    (new_rank)
  );

  // store half of a modify always hits the line just touched
  assign hit_inc = {1'b0, lk.hit} + {1'b0, req_modify};

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total   <= '0;
      miss_total  <= '0;
      evict_total <= '0;
    end else if (state == ST_LOOKUP && adv) begin
      hit_total   <= sat_add(hit_total, hit_inc);
      miss_total  <= sat_add(miss_total, {1'b0, !lk.hit});
      evict_total <= sat_add(evict_total, {1'b0, lk.evict});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_LOOKUP && adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOKUP && adv) begin
      res_hits  <= hit_inc;
      res_miss  <= !lk.hit;
      res_evict <= lk.evict;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, evict_total, miss_total, hit_total,
                    res_evict, res_miss, res_hits};

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    accept && !cfg_hit |=> state == ST_LOOKUP)
    else $error("accepted beat did not enter lookup");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR && clr_last && !cfg_hit |=> state == ST_IDLE)
    else $error("clearing pass did not finish on the last set");

  a_result_sane: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res_evict && !res_miss) && !(res_miss && res_hits == 2'd2)
                 && res_hits != 2'd3)
    else $error("inconsistent result flags");

  a_totals_hold: assert property (@(posedge clk) disable iff (rst)
    state != ST_LOOKUP |=> $stable(hit_total) && $stable(miss_total)
                           && $stable(evict_total))
    else $error("totals moved outside lookup");

endmodule
`default_nettype wire

[tb/tb_set_assoc_cache_lru_sim.sv]
`timescale 1ns / 1ps
module tb_set_assoc_cache_lru_sim;
  import sacl_pkg::*;

  localparam int SETS         = 1 << MAX_SET_BITS_DEF;
  localparam int WAYS         = MAX_WAYS_DEF;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 60;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 140;
  localparam int POOL_TAGS    = 8;
  localparam int POOL_SETS    = 3;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_STORE = 2'd1;
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [1:0]         hits_now;
    logic               miss_now;
    logic               evict_now;
    logic [TOTAL_W-1:0] total_hits;
    logic [TOTAL_W-1:0] total_misses;
    logic [TOTAL_W-1:0] total_evictions;
  } cache_result_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [1:0]            kind;
    logic [ADDR_W-1:0]     addr;
    bit                    typed;
    cache_result_t         res;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [ADDR_W-1:0]     s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  set_assoc_cache_lru_sim u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [ADDR_W-1:0]  tag_mem [SETS][WAYS];
  bit                 line_ok [SETS][WAYS];
  logic [1:0]         age [SETS][WAYS];
  logic [2:0]         cfg_set_bits;
  logic [5:0]         cfg_offset;
  logic [2:0]         cfg_ways;
  logic [TOTAL_W-1:0] sum_hits;
  logic [TOTAL_W-1:0] sum_misses;
  logic [TOTAL_W-1:0] sum_evicts;

  cache_result_t     pending_results[$];
  stim_row_t         directed_rows[$];
  logic [ADDR_W-1:0] pool_tag [POOL_TAGS];
  int                pool_set [POOL_SETS];
  int                src_pct = 0;
  int                sink_pct = 0;
  int                beats_in = 0;
  int                hold_left = 0;
  bit                hold_done = 1'b0;
  int                quiet_cycles = 0;
  int                n_fail = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int live_ways();
    if (cfg_ways == 3'd0) return 1;
    if (cfg_ways > WAYS) return WAYS;
    return int'(cfg_ways);
  endfunction

  function automatic int live_set_bits();
    return (cfg_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : int'(cfg_set_bits);
  endfunction

  function automatic void flush_cache();
    int w;
    w = live_ways();
    for (int s = 0; s < SETS; s++) begin
      for (int j = 0; j < WAYS; j++) begin
        tag_mem[s][j] = '0;
        line_ok[s][j] = 1'b0;
        age[s][j] = (j < w) ? 2'(w - 1 - j) : 2'd0;
      end
    end
  endfunction

  function automatic logic [TOTAL_W-1:0] bump(input logic [TOTAL_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // 0 hit, 1 cold miss, 2 miss that evicts a valid line
  function automatic int touch_line(input logic [ADDR_W-1:0] addr);
    int         w;
    int         sb;
    int         row_sel;
    int         found;
    int         victim;
    int         outcome;
    logic [ADDR_W-1:0] blk;
    logic [ADDR_W-1:0] tag;
    logic [1:0] r;
    w = live_ways();
    sb = live_set_bits();
    blk = addr >> cfg_offset;
    row_sel = int'(blk & ((64'd1 << sb) - 64'd1));
    tag = blk >> sb;
    found = -1;
    victim = 0;
    for (int i = 0; i < w; i++)
      if (line_ok[row_sel][i] && tag_mem[row_sel][i] == tag) found = i;
    if (found >= 0) begin
      r = age[row_sel][found];
      for (int i = 0; i < w; i++)
        if (age[row_sel][i] < r) age[row_sel][i] = age[row_sel][i] + 2'd1;
      age[row_sel][found] = 2'd0;
      sum_hits = bump(sum_hits);
      return 0;
    end
    for (int i = 0; i < w; i++)
      if (int'(age[row_sel][i]) == w - 1) victim = i;
    outcome = 1;
    if (line_ok[row_sel][victim]) begin
      sum_evicts = bump(sum_evicts);
      outcome = 2;
    end
    tag_mem[row_sel][victim] = tag;
    line_ok[row_sel][victim] = 1'b1;
    sum_misses = bump(sum_misses);
    for (int i = 0; i < w; i++)
      age[row_sel][i] = 2'((int'(age[row_sel][i]) + 1) % w);
    return outcome;
  endfunction

  function automatic cache_result_t predict_access(input logic [1:0] kind,
                                                   input logic [ADDR_W-1:0] addr);
    cache_result_t res;
    int            passes;
    int            outcome;
    res = '0;
    passes = (kind == REQ_MODIFY) ? 2 : 1;
    for (int k = 0; k < passes; k++) begin
      outcome = touch_line(addr);
      if (outcome == 0) res.hits_now = res.hits_now + 2'd1;
      else begin
        res.miss_now = 1'b1;
        if (outcome == 2) res.evict_now = 1'b1;
      end
    end
    res.total_hits = sum_hits;
    res.total_misses = sum_misses;
    res.total_evictions = sum_evicts;
    return res;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_SET_BITS: cfg_set_bits = val[2:0];
      REG_OFFSET_BITS: cfg_offset = val;
      REG_WAYS: cfg_ways = val[2:0];
      default: return;
    endcase
    flush_cache();
  endfunction

  function automatic logic [ADDR_W-1:0] next_address();
    logic [ADDR_W-1:0] noise;
    logic [ADDR_W-1:0] blk;
    int                sb;
    noise = {$urandom, $urandom};
    if ($urandom_range(99) < 25) return noise;
    sb = live_set_bits();
    blk = (pool_tag[$urandom_range(POOL_TAGS - 1)] << sb) |
          (64'(pool_set[$urandom_range(POOL_SETS - 1)]) & ((64'd1 << sb) - 64'd1));
    return (blk << cfg_offset) | (noise & ((64'd1 << cfg_offset) - 64'd1));
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_access(input logic [1:0] kind, input logic [ADDR_W-1:0] addr);
    stim_row_t row;
    row = '{default: '0};
    row.kind = kind;
    row.addr = addr;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_typed(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                                    input logic [1:0] hits, input logic miss,
                                    input logic evict, input int th, input int tm,
                                    input int te);
    stim_row_t row;
    row = '{default: '0};
    row.kind = kind;
    row.addr = addr;
    row.typed = 1'b1;
    row.res = '{hits, miss, evict, TOTAL_W'(th), TOTAL_W'(tm), TOTAL_W'(te)};
    directed_rows.push_back(row);
  endfunction

  task automatic send_access(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                             input bit typed, input cache_result_t typed_res);
    cache_result_t res;
    if (src_pct != 0 && $urandom_range(99) < src_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < src_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= addr;
    do @(posedge clk); while (!s_tready);
    res = predict_access(kind, addr);
    pending_results.push_back(typed ? typed_res : res);
    beats_in++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_left == 0 && !hold_done && beats_in >= HOLD_AT) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_pct);
    end
  end

  always @(posedge clk) begin : result_check
    cache_result_t got;
    cache_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.hits_now = m_tdata[1:0];
      got.miss_now = m_tdata[2];
      got.evict_now = m_tdata[3];
      got.total_hits = m_tdata[4 +: TOTAL_W];
      got.total_misses = m_tdata[4 + TOTAL_W +: TOTAL_W];
      got.total_evictions = m_tdata[4 + 2 * TOTAL_W +: TOTAL_W];
      if (pending_results.size() == 0) begin
        $error("result beat with no access pending");
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        if (got.hits_now !== want.hits_now) begin
          $error("hits_now expected %0d got %0d", want.hits_now, got.hits_now);
          n_fail++;
        end
        if (got.miss_now !== want.miss_now) begin
          $error("miss_now expected %0d got %0d", want.miss_now, got.miss_now);
          n_fail++;
        end
        if (got.evict_now !== want.evict_now) begin
          $error("evict_now expected %0d got %0d", want.evict_now, got.evict_now);
          n_fail++;
        end
        if (got.total_hits !== want.total_hits) begin
          $error("total_hits expected %0d got %0d", want.total_hits, got.total_hits);
          n_fail++;
        end
        if (got.total_misses !== want.total_misses) begin
          $error("total_misses expected %0d got %0d", want.total_misses, got.total_misses);
          n_fail++;
        end
        if (got.total_evictions !== want.total_evictions) begin
          $error("total_evictions expected %0d got %0d",
                 want.total_evictions, got.total_evictions);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("set_assoc_cache_lru_sim test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t  row;
    static idle_mode_t phase_mode [PHASES] = '{IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH,
                                               IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH};
    static int  phase_sb [PHASES] = '{2, 6, 0, 3, 7, 1, 4, 0};
    static int  phase_off [PHASES] = '{4, 6, 0, 5, 63, 32, 2, 0};
    static int  phase_ways [PHASES] = '{2, 4, 1, 3, 0, 5, 4, 1};
    int         sb;
    int         off;
    int         nw;

    cfg_set_bits = 3'd0;
    cfg_offset = 6'd0;
    cfg_ways = 3'd1;
    sum_hits = '0;
    sum_misses = '0;
    sum_evicts = '0;
    flush_cache();

    // cold cache, one way, no set or offset bits
    add_typed(REQ_LOAD, 64'd0, 2'd0, 1'b1, 1'b0, 0, 1, 0);
    add_typed(REQ_STORE, 64'd0, 2'd1, 1'b0, 1'b0, 1, 1, 0);
    add_typed(REQ_MODIFY, '1, 2'd1, 1'b1, 1'b1, 2, 2, 1);
    add_typed(REQ_SPARE, '1, 2'd1, 1'b0, 1'b0, 3, 2, 1);
    add_cfg(REG_WAYS, 6'd4);
    add_cfg(REG_SET_BITS, 6'd7);
    // flushed by the writes, totals kept
    add_typed(REQ_LOAD, 64'd0, 2'd0, 1'b1, 1'b0, 3, 3, 1);
    add_cfg(REG_OFFSET_BITS, 6'd63);
    add_access(REQ_LOAD, 64'h8000_0000_0000_0000);
    add_access(REQ_LOAD, 64'h7fff_ffff_ffff_ffff);
    add_access(REQ_MODIFY, '1);
    add_cfg(REG_OFFSET_BITS, 6'd4);
    for (int k = 1; k <= 5; k++) add_access(REQ_LOAD, 64'(k) << 10);
    add_access(REQ_STORE, 64'h400);
    add_access(REQ_MODIFY, 64'h1400);
    add_cfg(REG_WAYS, 6'd0);
    add_access(REQ_LOAD, 64'h10);
    add_access(REQ_LOAD, 64'h410);
    add_cfg(REG_UNUSED, 6'd63);
    add_access(REQ_STORE, 64'h410);
    add_cfg(REG_WAYS, 6'd7);
    add_access(REQ_SPARE, 64'haaaa_aaaa_aaaa_aaaa);
    add_access(REQ_MODIFY, 64'h5555_5555_5555_5555);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) write_reg(row.idx, row.val);
      else send_access(row.kind, row.addr, row.typed, row.res);
    end

    for (int p = 0; p < PHASES; p++) begin
      sb = phase_sb[p];
      off = phase_off[p];
      nw = phase_ways[p];
      if (p == PHASES - 1) begin
        sb = $urandom_range(7);
        off = $urandom_range(63);
        nw = $urandom_range(7);
      end
      write_reg(REG_SET_BITS, CFG_DATA_W'(sb));
      write_reg(REG_OFFSET_BITS, CFG_DATA_W'(off));
      write_reg(REG_WAYS, CFG_DATA_W'(nw));
      src_pct = (phase_mode[p] == IDLE_SRC) ? 80 : (phase_mode[p] == IDLE_BOTH) ? 32 : 0;
      sink_pct <= (phase_mode[p] == IDLE_SINK) ? 80 : (phase_mode[p] == IDLE_BOTH) ? 32 : 0;
      for (int t = 0; t < POOL_TAGS; t++) pool_tag[t] = {$urandom, $urandom};
      for (int s = 0; s < POOL_SETS; s++) pool_set[s] = $urandom_range(SETS - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == PHASE_ITEMS / 2) begin
          // hold the sender until the block has drained
          s_tvalid <= 1'b0;
          do @(negedge clk); while (pending_results.size() != 0);
        end
        send_access(2'($urandom_range(3)), next_address(), 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (n_fail == 0) begin
      $display("set_assoc_cache_lru_sim test passed");
    end else begin
      $display("set_assoc_cache_lru_sim test failed");
    end
    $finish;
  end

endmodule
